FILE: hw/rtl/shelf_atlas_packer_assert.svh
// Assertion macros shared by the packer's checker.
// No dependencies; include once per file that asserts.
`ifndef SHELF_ATLAS_PACKER_ASSERT_SVH
`define SHELF_ATLAS_PACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SAP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shelf packer assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define SAP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shelf packer assertion failed");

`endif

FILE: hw/rtl/sap_pkg.sv
// Shared types and constants of the shelf atlas packer.
// No dependencies; used by every module of the block.
package sap_pkg;

  localparam int DIM_BITS = 15;
  localparam int SIZE_BITS = 16;
  // Command index and count fields cover block counts up to 64
  localparam int CMD_IDX_BITS = 6;
  localparam int CMD_CNT_BITS = 7;
  localparam logic [SIZE_BITS-1:0] MAXDIM_CAP = 16'd32768;
  localparam logic [SIZE_BITS-1:0] MAXDIM_RESET = 16'd16384;

  typedef struct packed {
    logic [DIM_BITS-1:0] block_width;
    logic [DIM_BITS-1:0] block_height;
    logic                last_block;
  } in_item_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]  offset_x;
    logic [DIM_BITS-1:0]  offset_y;
    logic                 placed;
    logic [SIZE_BITS-1:0] atlas_width;
    logic [SIZE_BITS-1:0] atlas_height;
    logic                 last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_KEY,
    OP_RANK,
    OP_PLACE,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_SQ_FIN,
    OP_TGT_SQRT,
    OP_TINIT,
    OP_PREAD,
    OP_PSTEP,
    OP_EVAL1,
    OP_EVAL2,
    OP_PREFIX,
    OP_TGT_PREFIX
  } dp_op_t;

  typedef struct packed {
    dp_op_t                  op;
    logic [CMD_IDX_BITS-1:0] idx;
    logic [CMD_IDX_BITS-1:0] bit_sel;
    logic                    close;
    logic                    emit;
    logic                    last;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_CNT_BITS-1:0] nonempty;
  } dp_stat_t;

endpackage

FILE: hw/rtl/sap_ctrl.sv
// Sequencer of the shelf atlas packer: load, rank sort, square root,
// packing passes and emission. Depends on sap_pkg.
module sap_ctrl #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              last_block,
  output logic              busy,
  output sap_pkg::dp_cmd_t  cmd,
  input  sap_pkg::dp_stat_t stat
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AB = 2 * sap_pkg::DIM_BITS + CW;
  localparam int RB = (AB + 1) / 2;
  localparam int BW = $clog2(RB + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_KEY, S_RANK, S_PLACE, S_SQ_INIT, S_SQ_STEP, S_SQ_FIN, S_TGT_S,
    S_TINIT, S_PREAD, S_PSTEP, S_EVAL1, S_EVAL2, S_PREFIX, S_TGT_P, S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   total_r, total_nxt;
  logic [CW-1:0]   a_r, a_nxt;
  logic [CW-1:0]   b_r, b_nxt;
  logic [CW-1:0]   c_r, c_nxt;
  logic [BW-1:0]   bit_r, bit_nxt;
  logic            busy_r;
  logic [CW-1:0]   n_cnt;
  logic            accept;
  logic            close;

  assign n_cnt  = stat.nonempty[CW-1:0];
  assign accept = start && !busy_r;
  assign close  = last_block || (cnt_r == CW'(MAX_BLOCKS - 1));
  assign busy   = busy_r;

  // Drive datapath command from state and counters
  always_comb begin
    cmd = '0;
    cmd.op = sap_pkg::OP_NONE;
    unique case (state_r)
      S_LOAD: begin
        cmd.op = sap_pkg::OP_LOAD;
        cmd.idx = sap_pkg::CMD_IDX_BITS'(cnt_r);
        cmd.close = close;
      end
      S_KEY: begin
        cmd.op = sap_pkg::OP_KEY;
        cmd.idx = sap_pkg::CMD_IDX_BITS'(a_r);
      end
      S_RANK: begin
        cmd.op = sap_pkg::OP_RANK;
        cmd.idx = sap_pkg::CMD_IDX_BITS'(b_r);
      end
      S_PLACE:   cmd.op = sap_pkg::OP_PLACE;
      S_SQ_INIT: cmd.op = sap_pkg::OP_SQ_INIT;
      S_SQ_STEP: begin
        cmd.op = sap_pkg::OP_SQ_STEP;
        cmd.bit_sel = sap_pkg::CMD_IDX_BITS'(bit_r);
      end
      S_SQ_FIN:  cmd.op = sap_pkg::OP_SQ_FIN;
      S_TGT_S:   cmd.op = sap_pkg::OP_TGT_SQRT;
      S_TINIT:   cmd.op = sap_pkg::OP_TINIT;
      S_PREAD: begin
        cmd.op = sap_pkg::OP_PREAD;
        cmd.idx = sap_pkg::CMD_IDX_BITS'(b_r);
      end
      S_PSTEP:   cmd.op = sap_pkg::OP_PSTEP;
      S_EVAL1:   cmd.op = sap_pkg::OP_EVAL1;
      S_EVAL2:   cmd.op = sap_pkg::OP_EVAL2;
      S_PREFIX: begin
        cmd.op = sap_pkg::OP_PREFIX;
        cmd.idx = sap_pkg::CMD_IDX_BITS'(c_r);
      end
      S_TGT_P:   cmd.op = sap_pkg::OP_TGT_PREFIX;
      S_EMIT: begin
        cmd.op = sap_pkg::OP_NONE;
        cmd.emit = 1'b1;
        cmd.idx = sap_pkg::CMD_IDX_BITS'(a_r);
        cmd.last = (a_r == total_r - 1'b1);
      end
      default: cmd.op = sap_pkg::OP_NONE;
    endcase
  end

  // Advance the sequence
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          cnt_nxt = cnt_r + 1'b1;
          if (close) begin
            total_nxt = cnt_r + 1'b1;
            a_nxt = '0;
            state_nxt = S_KEY;
          end
        end
      end
      S_KEY: begin
        b_nxt = '0;
        state_nxt = S_RANK;
      end
      S_RANK: begin
        if (b_r == total_r - 1'b1) state_nxt = S_PLACE;
        else b_nxt = b_r + 1'b1;
      end
      S_PLACE: begin
        if (a_r == total_r - 1'b1) begin
          state_nxt = S_SQ_INIT;
        end else begin
          a_nxt = a_r + 1'b1;
          state_nxt = S_KEY;
        end
      end
      S_SQ_INIT: begin
        bit_nxt = BW'(RB);
        state_nxt = S_SQ_STEP;
      end
      S_SQ_STEP: begin
        if (bit_r == '0) state_nxt = S_SQ_FIN;
        else bit_nxt = bit_r - 1'b1;
      end
      S_SQ_FIN: state_nxt = S_TGT_S;
      S_TGT_S: begin
        c_nxt = '0;
        state_nxt = S_TINIT;
      end
      S_TINIT: begin
        b_nxt = '0;
        state_nxt = (n_cnt == '0) ? S_EVAL1 : S_PREAD;
      end
      S_PREAD: state_nxt = S_PSTEP;
      S_PSTEP: begin
        if (b_r == n_cnt - 1'b1) begin
          state_nxt = S_EVAL1;
        end else begin
          b_nxt = b_r + 1'b1;
          state_nxt = S_PREAD;
        end
      end
      S_EVAL1: state_nxt = S_EVAL2;
      S_EVAL2: begin
        if (c_r == n_cnt) begin
          a_nxt = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_PREFIX;
        end
      end
      S_PREFIX: state_nxt = S_TGT_P;
      S_TGT_P: begin
        c_nxt = c_r + 1'b1;
        state_nxt = S_TINIT;
      end
      S_EMIT: begin
        if (a_r == total_r - 1'b1) begin
          cnt_nxt = '0;
          state_nxt = S_LOAD;
        end else begin
          a_nxt = a_r + 1'b1;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Hold state, counters and busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      total_r <= '0;
      a_r     <= '0;
      b_r     <= '0;
      c_r     <= '0;
      bit_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      c_r     <= c_nxt;
      bit_r   <= bit_nxt;
      busy_r  <= (state_nxt != S_LOAD);
    end
  end

endmodule

FILE: hw/rtl/sap_datapath.sv
// Datapath of the shelf atlas packer: block stores, sort ranks, root unit,
// shelf cursor, trial and best banks, result register. Depends on sap_pkg.
module sap_datapath #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  sap_pkg::in_item_t             in_data,
  input  logic                          cfg_we,
  input  logic [sap_pkg::SIZE_BITS-1:0] cfg_data,
  input  sap_pkg::dp_cmd_t              cmd,
  output sap_pkg::dp_stat_t             stat,
  output logic                          out_valid,
  output sap_pkg::out_item_t            out_data
);

  localparam int D  = sap_pkg::DIM_BITS;
  localparam int S  = sap_pkg::SIZE_BITS;
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AB = 2 * D + CW;
  localparam int RB = (AB + 1) / 2 + 1;
  localparam int QW = 2 * RB;
  localparam int PB = D + CW;

  logic [D-1:0]  w_mem_r [MAX_BLOCKS];
  logic [D-1:0]  h_mem_r [MAX_BLOCKS];
  logic [IW-1:0] ord_r   [MAX_BLOCKS];
  logic [D-1:0]  tx_r    [2][MAX_BLOCKS];
  logic [D-1:0]  ty_r    [2][MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] tmask_r, bmask_r;

  logic [S-1:0]  maxdim_r, md;
  logic [D-1:0]  key_w_r, key_h_r;
  logic [IW-1:0] key_i_r, rank_r;
  logic          key_ok_r;
  logic [CW-1:0] nne_r;
  logic [AB-1:0] area_r;
  logic [RB-1:0] root_r;
  logic [PB-1:0] prefix_r;
  logic [S-1:0]  target_r;

  logic [S-1:0]  x_r, y_r, hh_r, aw_r, ah_r;
  logic [CW-1:0] tcnt_r;
  logic [D-1:0]  rd_w_r, rd_h_r;
  logic [IW-1:0] rd_i_r;

  logic [S-1:0]  side_r;
  logic [2*S-1:0] tarea_r;
  logic          bvalid_r, bsel_r;
  logic [CW-1:0] bc_r;
  logic [S-1:0]  bw_r, bh_r, bside_r;
  logic [2*S-1:0] barea_r;
  logic          out_valid_r;
  sap_pkg::out_item_t out_r;

  logic [IW-1:0] idx;
  logic [IW-1:0] rd_addr;
  logic [D-1:0]  rd_w, rd_h;
  logic          j_ok, j_before;
  logic [2*D-1:0] key_area;
  logic [RB-1:0] sq_trial;
  logic [QW-1:0] sq_prod, root_sq, area_ext;

  logic          fits, wrap, room;
  logic [S:0]    x_plus_w, y_plus_hh;
  logic [S-1:0]  x1, y1, hh1, hh2, x2, y2h;
  logic [S:0]    y1_plus_h;
  logic          better;

  assign idx = cmd.idx[IW-1:0];
  assign md  = (maxdim_r > sap_pkg::MAXDIM_CAP) ? sap_pkg::MAXDIM_CAP : maxdim_r;

  // Clamp a candidate row width to 1..md
  function automatic logic [S-1:0] clamp_w(input logic [31:0] v, input logic [S-1:0] lim);
    logic [S-1:0] r;
    if (v == 32'd0) r = 16'd1;
    else if (v > {16'd0, lim}) r = lim;
    else r = v[S-1:0];
    return r;
  endfunction

  // Select the one store read address
  always_comb begin
    case (cmd.op) inside
      sap_pkg::OP_PREAD, sap_pkg::OP_PREFIX: rd_addr = ord_r[idx];
      default: rd_addr = idx;
    endcase
  end
  assign rd_w = w_mem_r[rd_addr];
  assign rd_h = h_mem_r[rd_addr];

  // Rank compare: does entry j sort ahead of the held key
  assign j_ok = (rd_w != '0) && (rd_h != '0);
  assign j_before = (rd_h > key_h_r) ||
                    ((rd_h == key_h_r) && ((rd_w > key_w_r) ||
                     ((rd_w == key_w_r) && (idx < key_i_r))));
  assign key_area = key_w_r * key_h_r;

  // Root unit, one result bit per step
  assign sq_trial = root_r | (RB'(1) << cmd.bit_sel);
  assign sq_prod  = sq_trial * sq_trial;
  assign root_sq  = root_r * root_r;
  assign area_ext = QW'(area_r);

  // Shelf step for the block read in the previous cycle
  assign fits      = ({1'b0, rd_w_r} <= md) && ({1'b0, rd_h_r} <= md);
  assign x_plus_w  = {1'b0, x_r} + (S + 1)'(rd_w_r);
  assign wrap      = (x_plus_w > {1'b0, target_r}) && (x_r != '0);
  assign y_plus_hh = {1'b0, y_r} + {1'b0, hh_r};
  assign x1        = wrap ? '0 : x_r;
  assign y1        = wrap ? y_plus_hh[S-1:0] : y_r;
  assign hh1       = wrap ? '0 : hh_r;
  assign y1_plus_h = {1'b0, y1} + (S + 1)'(rd_h_r);
  assign room      = y1_plus_h <= {1'b0, md};
  assign x2        = x1 + S'(rd_w_r);
  assign hh2       = (S'(rd_h_r) > hh1) ? S'(rd_h_r) : hh1;
  assign y2h       = y1 + hh2;

  // Rank trial against best
  assign better = !bvalid_r || (tcnt_r > bc_r) ||
                  ((tcnt_r == bc_r) && (side_r < bside_r)) ||
                  ((tcnt_r == bc_r) && (side_r == bside_r) && (tarea_r < barea_r));

  // Hold stores and banks; no reset on payload
  always_ff @(posedge clk) begin
    if ((cmd.op == sap_pkg::OP_LOAD) && accept) begin
      w_mem_r[idx] <= in_data.block_width;
      h_mem_r[idx] <= in_data.block_height;
    end
    if ((cmd.op == sap_pkg::OP_PLACE) && key_ok_r) begin
      ord_r[rank_r] <= key_i_r;
    end
    if ((cmd.op == sap_pkg::OP_PSTEP) && fits && room) begin
      tx_r[~bsel_r][rd_i_r] <= x1[D-1:0];
      ty_r[~bsel_r][rd_i_r] <= y1[D-1:0];
    end
  end

  // Advance the datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxdim_r    <= sap_pkg::MAXDIM_RESET;
      nne_r       <= '0;
      area_r      <= '0;
      prefix_r    <= '0;
      tmask_r     <= '0;
      bmask_r     <= '0;
      bvalid_r    <= 1'b0;
      bsel_r      <= 1'b0;
      tcnt_r      <= '0;
      bc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) maxdim_r <= cfg_data;
      out_valid_r <= cmd.emit;
      case (cmd.op)
        sap_pkg::OP_LOAD: begin
          if (accept && cmd.close) begin
            nne_r    <= '0;
            area_r   <= '0;
            prefix_r <= '0;
            bvalid_r <= 1'b0;
            bmask_r  <= '0;
          end
        end
        sap_pkg::OP_KEY: begin
          key_w_r  <= rd_w;
          key_h_r  <= rd_h;
          key_i_r  <= idx;
          key_ok_r <= j_ok;
          rank_r   <= '0;
        end
        sap_pkg::OP_RANK: begin
          if (j_ok && j_before) rank_r <= rank_r + 1'b1;
        end
        sap_pkg::OP_PLACE: begin
          if (key_ok_r) begin
            nne_r  <= nne_r + 1'b1;
            area_r <= area_r + AB'(key_area);
          end
        end
        sap_pkg::OP_SQ_INIT: root_r <= '0;
        sap_pkg::OP_SQ_STEP: begin
          if (sq_prod <= area_ext) root_r <= sq_trial;
        end
        sap_pkg::OP_SQ_FIN: begin
          if (root_sq < area_ext) root_r <= root_r + 1'b1;
        end
        sap_pkg::OP_TGT_SQRT: target_r <= clamp_w(32'(root_r), md);
        sap_pkg::OP_PREFIX: prefix_r <= prefix_r + PB'(rd_w);
        sap_pkg::OP_TGT_PREFIX: target_r <= clamp_w(32'(prefix_r), md);
        sap_pkg::OP_TINIT: begin
          x_r     <= '0;
          y_r     <= '0;
          hh_r    <= '0;
          aw_r    <= '0;
          ah_r    <= '0;
          tcnt_r  <= '0;
          tmask_r <= '0;
        end
        sap_pkg::OP_PREAD: begin
          rd_w_r <= rd_w;
          rd_h_r <= rd_h;
          rd_i_r <= rd_addr;
        end
        sap_pkg::OP_PSTEP: begin
          if (fits) begin
            y_r <= y1;
            if (room) begin
              tmask_r[rd_i_r] <= 1'b1;
              tcnt_r <= tcnt_r + 1'b1;
              x_r    <= x2;
              hh_r   <= hh2;
              if (x2 > aw_r) aw_r <= x2;
              if (y2h > ah_r) ah_r <= y2h;
            end else begin
              x_r  <= x1;
              hh_r <= hh1;
            end
          end
        end
        sap_pkg::OP_EVAL1: begin
          side_r  <= (aw_r > ah_r) ? aw_r : ah_r;
          tarea_r <= aw_r * ah_r;
        end
        sap_pkg::OP_EVAL2: begin
          if (better) begin
            bvalid_r <= 1'b1;
            bc_r     <= tcnt_r;
            bw_r     <= aw_r;
            bh_r     <= ah_r;
            bside_r  <= side_r;
            barea_r  <= tarea_r;
            bmask_r  <= tmask_r;
            bsel_r   <= ~bsel_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Register one result per emit cycle
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.placed       <= bmask_r[idx];
      out_r.offset_x     <= bmask_r[idx] ? tx_r[bsel_r][idx] : '0;
      out_r.offset_y     <= bmask_r[idx] ? ty_r[bsel_r][idx] : '0;
      out_r.atlas_width  <= bw_r;
      out_r.atlas_height <= bh_r;
      out_r.last_result  <= cmd.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign stat.nonempty = sap_pkg::CMD_CNT_BITS'(nne_r);

endmodule

FILE: hw/rtl/shelf_atlas_packer.sv
// Top level of the shelf atlas packer: sequencer plus datapath.
// Depends on sap_pkg, sap_ctrl and sap_datapath.
//
//  channel | ports                         | handshake
//  input   | start, busy, in_data          | taken when start && !busy
//  result  | out_valid, out_data           | one-cycle strobe, always taken
//  config  | cfg_valid, cfg_ready, cfg_data| written when valid && ready
//
// Each accepted block is stored; the closing block starts the solve.
// Solve for T loaded and n non-empty blocks: a rank sort, a bit-serial root
// of the total area, (n+1) passes of the shared shelf unit with a prefix
// width step after each pass but the last, then T results are emitted.
// Reset (synchronous) empties the set and sets max_dimension to 16384.
// cfg_ready is always high; results cannot be stalled.
module shelf_atlas_packer #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  sap_pkg::in_item_t             in_data,
  output logic                          out_valid,
  output sap_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sap_pkg::SIZE_BITS-1:0] cfg_data
);

  sap_pkg::dp_cmd_t  cmd;
  sap_pkg::dp_stat_t stat;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  sap_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .last_block (in_data.last_block),
    .busy       (busy),
    .cmd        (cmd),
    .stat       (stat)
  );

  sap_datapath #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/sap_checker.sv
// Port-level checks of the shelf atlas packer, bound to the top level.
// Depends on sap_pkg and shelf_atlas_packer_assert.svh.
`include "shelf_atlas_packer_assert.svh"

module sap_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          busy,
  input logic                          out_valid,
  input sap_pkg::out_item_t            out_data
);

  // Results of one set come in an unbroken run
  `SAP_ASSERT_NEXT(a_run_contiguous, out_valid && !out_data.last_result, out_valid)
  // A set's last item is followed by a gap
  `SAP_ASSERT_NEXT(a_gap_after_last, out_valid && out_data.last_result, !out_valid)
  // Mid-run results are given while no new item can enter
  `SAP_ASSERT_IMPL(a_busy_in_run, out_valid && !out_data.last_result, busy)
  // A placed item implies a non-empty atlas
  `SAP_ASSERT_IMPL(a_atlas_nonempty, out_valid && out_data.placed,
    (out_data.atlas_width != 16'd0) && (out_data.atlas_height != 16'd0))

endmodule

bind shelf_atlas_packer sap_checker u_sap_checker (.*);
